>>> rtl/alle_pkg.sv
// Shared types and codes for the array linked list engine.
// No dependencies; imported by alle_ctrl and array_linked_list_engine.
`default_nettype none

package alle_pkg;

    localparam int SLOT_W  = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_BADPREV  = 2'd3;

    localparam logic [SLOT_W-1:0] SLOT_NULL = 6'h3F;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
        logic signed [SLOT_W-1:0]  prev_slot;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [SLOT_W-1:0] found_prev;
        logic [COUNT_W-1:0]       count;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/alle_ctrl.sv
// Sequencer of the linked list engine with the value, link and free-slot memories.
// Depends on alle_pkg for the command and result types and the codes.
`default_nettype none

module alle_ctrl #(
    parameter int SLOTS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire alle_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    output alle_pkg::res_t     res,
    output logic               res_valid,
    input  wire logic          res_ready
);
    import alle_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef struct packed {
        logic          vld;
        logic [SW-1:0] idx;
    } ptr_t;

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_SCAN     = 9'b000000100,
        S_APP_LINK = 9'b000001000,
        S_FIND_CHK = 9'b000010000,
        S_RMH_CHK  = 9'b000100000,
        S_RMP_CHK  = 9'b001000000,
        S_RMV_CHK  = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    localparam ptr_t PTR_NULL = '{vld: 1'b0, idx: '0};

    logic [VALUE_W-1:0] value_mem [SLOTS];
    logic [SW:0]        next_mem  [SLOTS];
    logic               free_mem  [SLOTS];

    logic [VALUE_W-1:0] value_rd_reg;
    ptr_t               next_rd_reg;
    logic               free_rd_reg;

    state_t        state_reg, state_next;
    logic [SW-1:0] scan_reg, scan_next;
    ptr_t          head_reg, head_next;
    ptr_t          tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic [VALUE_W-1:0] val_reg, val_next;
    logic [SW-1:0]      pidx_reg, pidx_next;
    logic [SW-1:0]      cur_reg, cur_next;
    logic [SW-1:0]      slot_reg, slot_next;
    ptr_t               before_reg, before_next;
    logic [1:0]         status_reg, status_next;
    logic [SLOT_W-1:0]  fprev_reg, fprev_next;

    logic [SW-1:0]      rd_addr;
    logic               val_we;
    logic [SW-1:0]      val_waddr;
    logic [VALUE_W-1:0] val_wdata;
    logic               next_we;
    logic [SW-1:0]      next_waddr;
    ptr_t               next_wdata;
    logic               free_we;
    logic [SW-1:0]      free_waddr;
    logic               free_wdata;

    logic [SW+SLOT_W-1:0] p_ext;
    logic [SW+SLOT_W:0]   p_cmp;
    logic                 p_in_range;
    logic [SW-1:0]        p_idx;
    logic [SW+SLOT_W-1:0] before_ext;
    logic [CW+COUNT_W-1:0] count_ext;

    assign p_ext      = {{SW{1'b0}}, cmd.prev_slot};
    assign p_idx      = p_ext[SW-1:0];
    assign p_cmp      = {{(SW+1){1'b0}}, cmd.prev_slot};
    assign p_in_range = !cmd.prev_slot[SLOT_W-1] && (p_cmp < (SW+SLOT_W+1)'(SLOTS));
    assign before_ext = {{SLOT_W{1'b0}}, before_reg.idx};
    assign count_ext  = {{COUNT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next  = state_reg;
        scan_next   = scan_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        val_next    = val_reg;
        pidx_next   = pidx_reg;
        cur_next    = cur_reg;
        slot_next   = slot_reg;
        before_next = before_reg;
        status_next = status_reg;
        fprev_next  = fprev_reg;
        rd_addr     = cur_reg;
        val_we      = 1'b0;
        val_waddr   = slot_reg;
        val_wdata   = val_reg;
        next_we     = 1'b0;
        next_waddr  = slot_reg;
        next_wdata  = PTR_NULL;
        free_we     = 1'b0;
        free_waddr  = slot_reg;
        free_wdata  = 1'b0;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                free_we    = 1'b1;
                free_waddr = scan_reg;
                free_wdata = 1'b1;
                if (scan_reg == SW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                cmd_ready   = 1'b1;
                fprev_next  = '0;
                status_next = STAT_OK;
                val_next    = cmd.value;
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            if (count_reg == CW'(SLOTS))
                            begin
                                status_next = STAT_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                slot_next  = '0;
                                scan_next  = SW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        OP_FIND:
                        begin
                            if (!head_reg.vld)
                            begin
                                status_next = STAT_NOTFOUND;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                rd_addr     = head_reg.idx;
                                cur_next    = head_reg.idx;
                                before_next = PTR_NULL;
                                state_next  = S_FIND_CHK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cmd.prev_slot == SLOT_NULL)
                            begin
                                if (!head_reg.vld)
                                begin
                                    status_next = STAT_BADPREV;
                                    state_next  = S_RESP;
                                end
                                else
                                begin
                                    rd_addr    = head_reg.idx;
                                    state_next = S_RMH_CHK;
                                end
                            end
                            else if (!p_in_range)
                            begin
                                status_next = STAT_BADPREV;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                rd_addr    = p_idx;
                                pidx_next  = p_idx;
                                state_next = S_RMP_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (free_rd_reg)
                begin
                    val_we     = 1'b1;
                    val_waddr  = slot_reg;
                    next_we    = 1'b1;
                    next_waddr = slot_reg;
                    next_wdata = PTR_NULL;
                    free_we    = 1'b1;
                    free_waddr = slot_reg;
                    free_wdata = 1'b0;
                    state_next = S_APP_LINK;
                end
                else
                begin
                    rd_addr   = scan_reg;
                    slot_next = scan_reg;
                    if (scan_reg != SW'(SLOTS - 1))
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            S_APP_LINK:
            begin
                if (tail_reg.vld)
                begin
                    next_we    = 1'b1;
                    next_waddr = tail_reg.idx;
                    next_wdata = '{vld: 1'b1, idx: slot_reg};
                end
                else
                begin
                    head_next = '{vld: 1'b1, idx: slot_reg};
                end
                tail_next  = '{vld: 1'b1, idx: slot_reg};
                count_next = count_reg + 1'b1;
                state_next = S_RESP;
            end
            S_FIND_CHK:
            begin
                if (value_rd_reg == val_reg)
                begin
                    fprev_next = before_reg.vld ? before_ext[SLOT_W-1:0] : SLOT_NULL;
                    state_next = S_RESP;
                end
                else if (!next_rd_reg.vld)
                begin
                    status_next = STAT_NOTFOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    before_next = '{vld: 1'b1, idx: cur_reg};
                    cur_next    = next_rd_reg.idx;
                    rd_addr     = next_rd_reg.idx;
                end
            end
            S_RMH_CHK:
            begin
                free_we    = 1'b1;
                free_waddr = head_reg.idx;
                free_wdata = 1'b1;
                if ((tail_reg.idx == head_reg.idx) || !next_rd_reg.vld)
                begin
                    head_next = PTR_NULL;
                    tail_next = PTR_NULL;
                end
                else
                begin
                    head_next = next_rd_reg;
                end
                count_next = count_reg - 1'b1;
                state_next = S_RESP;
            end
            S_RMP_CHK:
            begin
                if (free_rd_reg || !next_rd_reg.vld)
                begin
                    status_next = STAT_BADPREV;
                    state_next  = S_RESP;
                end
                else
                begin
                    slot_next  = next_rd_reg.idx;
                    rd_addr    = next_rd_reg.idx;
                    state_next = S_RMV_CHK;
                end
            end
            S_RMV_CHK:
            begin
                next_we    = 1'b1;
                next_waddr = pidx_reg;
                next_wdata = next_rd_reg;
                free_we    = 1'b1;
                free_waddr = slot_reg;
                free_wdata = 1'b1;
                if (tail_reg.idx == slot_reg)
                begin
                    tail_next = '{vld: 1'b1, idx: pidx_reg};
                end
                count_next = count_reg - 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status     = status_reg;
    assign res.found_prev = fprev_reg;
    assign res.count      = count_ext[COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            scan_reg  <= '0;
            head_reg  <= PTR_NULL;
            tail_reg  <= PTR_NULL;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        pidx_reg   <= pidx_next;
        cur_reg    <= cur_next;
        slot_reg   <= slot_next;
        before_reg <= before_next;
        status_reg <= status_next;
        fprev_reg  <= fprev_next;
    end

    always_ff @(posedge clk)
    begin
        value_rd_reg <= value_mem[rd_addr];
        if (val_we)
        begin
            value_mem[val_waddr] <= val_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        next_rd_reg <= next_mem[rd_addr];
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        free_rd_reg <= free_mem[rd_addr];
        if (free_we)
        begin
            free_mem[free_waddr] <= free_wdata;
        end
    end

`ifndef ASSERT_OFF
    a_head_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg.vld == (count_reg != '0))
        else $error("Head pointer and node count disagree.");

    a_tail_tracks_head: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg.vld == head_reg.vld)
        else $error("Tail pointer and head pointer disagree on an empty list.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("Node count exceeds the number of slots.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1)))
        else $error("Node count changed by more than one in a cycle.");
`endif

endmodule

`default_nettype wire

>>> rtl/array_linked_list_engine.sv
// Top level of the array linked list engine: stream ports and the result register.
// Depends on alle_pkg and alle_ctrl.
//
//   Channel  Direction  Contents
//   s_axis   in         tuser: op; tdata: value, prev_slot
//   m_axis   out        tdata: status, found_prev, count
//
// Append scans the free map from slot 0 for the lowest free slot and links it at the tail.
// Find walks the nodes from the head; each step is one read of the link memory. Remove
// unlinks the head or the node after a given slot; a rejected predecessor answers with
// status BADPREV. A full append, an empty find or op 3 goes straight to the response.
// After reset the free map is cleared slot by slot before the first transfer is taken.
// A stalled result waits in the output register.
`default_nettype none

module array_linked_list_engine #(
    parameter int SLOTS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // value[31:0], prev_slot[37:32], zero pad
    input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // status[1:0], found_prev[7:2], count[13:8]
);
    import alle_pkg::*;

    cmd_t        cmd;
    res_t        res;
    logic        res_valid;
    logic        res_ready;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;

    assign cmd.op        = s_axis_tuser;
    assign cmd.value     = s_axis_tdata[31:0];
    assign cmd.prev_slot = s_axis_tdata[37:32];

    alle_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            out_data_next  = {2'b00, res.count, res.found_prev, res.status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
